/* hw/rtl/lzwc_pkg.sv */
// shared types and constants of the lzw compressor
package lzwc_pkg;

    localparam int CODE_OUT_W = 12;
    localparam int EPOCH_W    = 8;
    localparam int OUTQ_DEPTH = 4;

    typedef struct packed {
        logic                  bad;
        logic                  eos;
        logic [CODE_OUT_W-1:0] code;
    } res_t;

endpackage

/* hw/rtl/lzwc_outq.sv */
// four-entry result queue, takes up to two results per cycle
module lzwc_outq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push0,
    input  logic              push1,
    input  lzwc_pkg::res_t    res0,
    input  lzwc_pkg::res_t    res1,
    output logic              out_valid,
    input  logic              out_ready,
    output lzwc_pkg::res_t    out_res,
    output logic [2:0]        count
);

    lzwc_pkg::res_t ent_reg [lzwc_pkg::OUTQ_DEPTH];
    logic [1:0] wr_reg;
    logic [1:0] rd_reg;
    logic [2:0] cnt_reg;
    logic [1:0] wr_next;
    logic [1:0] rd_next;
    logic [2:0] cnt_next;
    logic       pop;

    assign out_valid = (cnt_reg != 3'd0);
    assign out_res   = ent_reg[rd_reg];
    assign count     = cnt_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next  = wr_reg + {1'b0, push0} + {1'b0, push1};
        rd_next  = rd_reg + {1'b0, pop};
        cnt_next = cnt_reg + {2'b0, push0} + {2'b0, push1} - {2'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            ent_reg[wr_reg] <= res0;
        end
        if (push1)
        begin
            ent_reg[wr_reg + 2'd1] <= res1;
        end
    end

endmodule

/* hw/rtl/lzw_compressor_top.sv */
// lzw compressor: hashed dictionary in one memory, sequential probe engine
// a bad byte, or a byte on an empty phrase, is settled in the beat itself; otherwise
//   the byte waits in the probe state while hash probes read the memory, one per probe
// input: no new byte while a probe runs; probes share the single dictionary read port
// reset: phrase empty, alphabet_size 255, then a clearing pass over all 2^(CODE_BITS+1) slots
//   with no byte taken; the same pass repeats every 255th stream restart (epoch wrap)
module lzw_compressor_top #(
    parameter int CODE_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // code[11:0], zero pad
    output logic        m_axis_tlast,   // end_of_stream
    output logic        m_axis_tuser,   // bad_symbol
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data        // alphabet_size
);

    localparam int HASH_BITS = CODE_BITS + 1;
    localparam int NF_W      = CODE_BITS + 1;
    localparam int EW        = lzwc_pkg::EPOCH_W;
    localparam int SLOT_W    = EW + CODE_BITS + 8 + CODE_BITS;
    localparam int NUM_SLOTS = 1 << HASH_BITS;
    localparam int NUM_CODES = 1 << CODE_BITS;
    localparam int OutW      = lzwc_pkg::CODE_OUT_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [7:0]           alpha_reg, alpha_next;
    logic [NF_W-1:0]      nf_reg, nf_next;
    logic [CODE_BITS-1:0] phrase_reg, phrase_next;
    logic                 pempty_reg, pempty_next;
    logic [EW-1:0]        epoch_reg, epoch_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic [HASH_BITS-1:0] probe_reg, probe_next;
    logic [HASH_BITS-1:0] clr_reg, clr_next;

    logic [SLOT_W-1:0]    mem [NUM_SLOTS];
    logic [SLOT_W-1:0]    mem_rdata;
    logic                 mem_we, mem_re;
    logic [HASH_BITS-1:0] mem_waddr, mem_raddr;
    logic [SLOT_W-1:0]    mem_wdata;

    logic                 push0, push1;
    lzwc_pkg::res_t       res0, res1, out_res;
    logic [2:0]           q_count;

    logic                 in_fire, cfg_fire, restart, bad, occupied, key_match;
    logic [HASH_BITS-1:0] hash;
    logic [EW-1:0]        rd_epoch;
    logic [CODE_BITS-1:0] rd_prefix, rd_code;
    logic [7:0]           rd_byte;

    // register write waits while a probe runs and takes priority over a data beat
    assign cfg_ready     = (state_reg != S_LOOK);
    assign s_axis_tready = (state_reg == S_IDLE) && (q_count <= 3'd2) && !cfg_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_fire      = cfg_valid && cfg_ready;

    assign bad  = (s_axis_tdata == 8'd0) || (s_axis_tdata > alpha_reg);
    assign hash = HASH_BITS'(phrase_reg)
                ^ (HASH_BITS'(s_axis_tdata) << (HASH_BITS - 8));

    assign rd_epoch  = mem_rdata[SLOT_W-1 -: EW];
    assign rd_prefix = mem_rdata[2*CODE_BITS+7 -: CODE_BITS];
    assign rd_byte   = mem_rdata[CODE_BITS+7 -: 8];
    assign rd_code   = mem_rdata[CODE_BITS-1:0];
    assign occupied  = (rd_epoch == epoch_reg);
    assign key_match = (rd_prefix == phrase_reg) && (rd_byte == byte_reg);

    always_comb
    begin
        state_next  = state_reg;
        alpha_next  = cfg_fire ? cfg_data : alpha_reg;
        nf_next     = nf_reg;
        phrase_next = phrase_reg;
        pempty_next = pempty_reg;
        epoch_next  = epoch_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        probe_next  = probe_reg;
        clr_next    = clr_reg;
        push0       = 1'b0;
        push1       = 1'b0;
        res0        = '0;
        res1        = '0;
        mem_we      = 1'b0;
        mem_waddr   = probe_reg;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = probe_reg;
        restart     = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                    epoch_next = EW'(1);
                end
                if (cfg_fire)
                begin
                    nf_next = NF_W'(cfg_data) + NF_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (bad)
                    begin
                        push0    = 1'b1;
                        res0.bad = 1'b1;
                        res0.eos = s_axis_tlast && pempty_reg;
                        if (s_axis_tlast)
                        begin
                            push1     = !pempty_reg;
                            res1.code = OutW'(phrase_reg);
                            res1.eos  = 1'b1;
                            restart   = 1'b1;
                        end
                    end
                    else if (pempty_reg)
                    begin
                        phrase_next = CODE_BITS'(s_axis_tdata);
                        pempty_next = 1'b0;
                        if (s_axis_tlast)
                        begin
                            push0     = 1'b1;
                            res0.code = OutW'(s_axis_tdata);
                            res0.eos  = 1'b1;
                            restart   = 1'b1;
                        end
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = hash;
                        probe_next = hash;
                        byte_next  = s_axis_tdata;
                        last_next  = s_axis_tlast;
                        state_next = S_LOOK;
                    end
                end
                else if (cfg_fire)
                begin
                    restart = 1'b1;
                end
            end
            S_LOOK:
            begin
                if (occupied && key_match)
                begin
                    phrase_next = rd_code;
                    state_next  = S_IDLE;
                    if (last_reg)
                    begin
                        push0     = 1'b1;
                        res0.code = OutW'(rd_code);
                        res0.eos  = 1'b1;
                        restart   = 1'b1;
                    end
                end
                else if (occupied)
                begin
                    // collision, try the next slot
                    probe_next = probe_reg + 1'b1;
                    mem_re     = 1'b1;
                    mem_raddr  = probe_reg + 1'b1;
                end
                else
                begin
                    push0     = 1'b1;
                    res0.code = OutW'(phrase_reg);
                    if (nf_reg < NF_W'(NUM_CODES))
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {epoch_reg, phrase_reg, byte_reg, nf_reg[CODE_BITS-1:0]};
                        nf_next   = nf_reg + 1'b1;
                    end
                    phrase_next = CODE_BITS'(byte_reg);
                    state_next  = S_IDLE;
                    if (last_reg)
                    begin
                        push1     = 1'b1;
                        res1.code = OutW'(byte_reg);
                        res1.eos  = 1'b1;
                        restart   = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase

        if (restart)
        begin
            nf_next     = NF_W'(alpha_next) + NF_W'(1);
            phrase_next = '0;
            pempty_next = 1'b1;
            // stale slots carry an old epoch; wrap forces a full sweep
            if (&epoch_reg)
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
            else
            begin
                epoch_next = epoch_reg + 1'b1;
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            alpha_reg  <= 8'd255;
            nf_reg     <= NF_W'(256);
            phrase_reg <= '0;
            pempty_reg <= 1'b1;
            epoch_reg  <= EW'(1);
            byte_reg   <= '0;
            last_reg   <= 1'b0;
            probe_reg  <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            alpha_reg  <= alpha_next;
            nf_reg     <= nf_next;
            phrase_reg <= phrase_next;
            pempty_reg <= pempty_next;
            epoch_reg  <= epoch_next;
            byte_reg   <= byte_next;
            last_reg   <= last_next;
            probe_reg  <= probe_next;
            clr_reg    <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= mem[mem_raddr];
        end
    end

    lzwc_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (push0),
        .push1     (push1),
        .res0      (res0),
        .res1      (res1),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res),
        .count     (q_count)
    );

    assign m_axis_tdata = {4'b0, out_res.code};
    assign m_axis_tlast = out_res.eos;
    assign m_axis_tuser = out_res.bad;

    a_look_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |-> (q_count <= 3'd2))
        else $error("probe running without room for two results");

    a_phrase_code: assert property (@(posedge clk) disable iff (!rst_n)
        !pempty_reg |-> (phrase_reg != '0))
        else $error("open phrase holds code zero");

    a_nf_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nf_reg > NF_W'(alpha_reg)) && (nf_reg <= NF_W'(NUM_CODES)))
        else $error("next free code out of range");

endmodule

/* sim/lzw_compressor_top_tb.sv */
// self-checking testbench of the lzw compressor: directed table, random streams, long stream
`timescale 1ns / 1ps

module lzw_compressor_top_tb;

    localparam int CODE_BITS   = 12;
    localparam int NUM_CODES   = 1 << CODE_BITS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 64;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [7:0]     data_byte;
        logic           last_byte;
        bit             typed;
        lzwc_pkg::res_t first_res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    // model state
    int unsigned alpha_size;
    int unsigned next_code;
    int unsigned phrase;
    bit          phrase_empty;
    int unsigned phrase_dict[bit [19:0]];

    lzwc_pkg::res_t pending_codes[$];
    int          err_count;
    int          cycle_count;
    int          beats_in;
    int          beats_out;
    int          streams_done;
    int          last_n;
    bit          steady;
    bit          hold_req;
    bit          hold_active;

    dir_row_t    dir_rows[20];

    lzw_compressor_top #(.CODE_BITS(CODE_BITS)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d codes still awaited",
                     cycle_count, pending_codes.size());
            $display("lzw_compressor_top_tb: done, errors");
            $finish;
        end
    end

    function automatic lzwc_pkg::res_t mk_res(int unsigned code, bit eos, bit bad);
        lzwc_pkg::res_t r;
        r.code = code[lzwc_pkg::CODE_OUT_W-1:0];
        r.eos  = eos;
        r.bad  = bad;
        return r;
    endfunction

    function automatic void restart_stream();
        next_code    = alpha_size + 1;
        phrase       = 0;
        phrase_empty = 1'b1;
        phrase_dict.delete();
        streams_done++;
    endfunction

    // pushes the codes that one byte produces, returns how many
    function automatic int lzw_predict(logic [7:0] b, logic last);
        bit [19:0] key;
        int        n;
        n = 0;
        if (b == 0 || b > alpha_size)
        begin
            pending_codes.push_back(mk_res(0, last && phrase_empty, 1'b1));
            n++;
            if (last)
            begin
                if (!phrase_empty)
                begin
                    pending_codes.push_back(mk_res(phrase, 1'b1, 1'b0));
                    n++;
                end
                restart_stream();
            end
            return n;
        end
        if (phrase_empty)
        begin
            phrase       = {24'd0, b};
            phrase_empty = 1'b0;
        end
        else
        begin
            key = {phrase[11:0], b};
            if (phrase_dict.exists(key))
                phrase = phrase_dict[key];
            else
            begin
                pending_codes.push_back(mk_res(phrase, 1'b0, 1'b0));
                n++;
                // no new entries once the last code is taken
                if (next_code < NUM_CODES)
                begin
                    phrase_dict[key] = next_code;
                    next_code++;
                end
                phrase = {24'd0, b};
            end
        end
        if (last)
        begin
            pending_codes.push_back(mk_res(phrase, 1'b1, 1'b0));
            n++;
            restart_stream();
        end
        return n;
    endfunction

    // one input beat, with random idle cycles in front unless steady
    task automatic send_byte(logic [7:0] b, logic last);
        bit acc;
        while (!steady && $urandom_range(99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
        begin
            @(negedge clk);
            acc = s_axis_tready;
            @(posedge clk);
        end
        while (!acc);
        last_n = lzw_predict(b, last);
        beats_in++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (pending_codes.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_alphabet(logic [7:0] v);
        bit acc;
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(negedge clk);
            acc = cfg_ready;
            @(posedge clk);
        end
        while (!acc);
        cfg_valid  <= 1'b0;
        alpha_size = {24'd0, v};
        restart_stream();
    endtask

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 86 || (alpha_size == 255 && r < 95))
            return 8'($urandom_range(1, alpha_size));
        if (alpha_size == 255 || r < 90)
            return 8'd0;
        return 8'($urandom_range(alpha_size + 1, 255));
    endfunction

    task automatic random_streams(int count);
        for (int i = 0; i < count; i++)
            send_byte(pick_byte(), ($urandom_range(24) == 0) || (i == count - 1));
    endtask

    // receiver: random stalls unless steady, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_active && (steady || $urandom_range(99) >= 22);
    end

    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            wait (hold_req);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active = 1'b0;
            hold_req    = 1'b0;
        end
    end

    // output beats are sampled mid-cycle, accepted at the next rising edge
    always @(negedge clk)
    begin
        lzwc_pkg::res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_out++;
            if (pending_codes.size() == 0)
            begin
                $display("%0t: unexpected code %0d eos %0b bad %0b", $time,
                         m_axis_tdata[11:0], m_axis_tlast, m_axis_tuser);
                err_count++;
            end
            else
            begin
                want = pending_codes.pop_front();
                if (m_axis_tdata[11:0] !== want.code)
                begin
                    $display("%0t: code expected %0d, got %0d", $time, want.code,
                             m_axis_tdata[11:0]);
                    err_count++;
                end
                if (m_axis_tlast !== want.eos)
                begin
                    $display("%0t: end_of_stream expected %0b, got %0b", $time, want.eos,
                             m_axis_tlast);
                    err_count++;
                end
                if (m_axis_tuser !== want.bad)
                begin
                    $display("%0t: bad_symbol expected %0b, got %0b", $time, want.bad,
                             m_axis_tuser);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        logic [7:0]  cfg_list[6];

        err_count     = 0;
        cycle_count   = 0;
        beats_in      = 0;
        beats_out     = 0;
        streams_done  = 0;
        last_n        = 0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 8'd0;
        alpha_size    = 255;
        restart_stream();
        streams_done  = 0;

        // typed rows check the first predicted result: bad bytes, single-byte streams, phrase codes
        dir_rows = '{
            '{8'd0,   1'b0, 1'b1, mk_res(0, 1'b0, 1'b1)},
            '{8'd65,  1'b0, 1'b0, mk_res(0, 1'b0, 1'b0)},
            '{8'd66,  1'b0, 1'b1, mk_res(65, 1'b0, 1'b0)},
            '{8'd65,  1'b0, 1'b1, mk_res(66, 1'b0, 1'b0)},
            '{8'd66,  1'b0, 1'b0, mk_res(0, 1'b0, 1'b0)},
            '{8'd65,  1'b1, 1'b0, mk_res(0, 1'b0, 1'b0)},
            '{8'd255, 1'b1, 1'b1, mk_res(255, 1'b1, 1'b0)},
            '{8'd0,   1'b1, 1'b1, mk_res(0, 1'b1, 1'b1)},
            '{8'd7,   1'b0, 1'b0, mk_res(0, 1'b0, 1'b0)},
            '{8'd0,   1'b1, 1'b1, mk_res(0, 1'b0, 1'b1)},
            '{8'd1,   1'b0, 1'b0, mk_res(0, 1'b0, 1'b0)},
            '{8'd1,   1'b0, 1'b1, mk_res(1, 1'b0, 1'b0)},
            '{8'd1,   1'b0, 1'b0, mk_res(0, 1'b0, 1'b0)},
            '{8'd1,   1'b0, 1'b0, mk_res(0, 1'b0, 1'b0)},
            '{8'd1,   1'b1, 1'b0, mk_res(0, 1'b0, 1'b0)},
            '{8'd170, 1'b0, 1'b0, mk_res(0, 1'b0, 1'b0)},
            '{8'd0,   1'b0, 1'b1, mk_res(0, 1'b0, 1'b1)},
            '{8'd85,  1'b0, 1'b1, mk_res(170, 1'b0, 1'b0)},
            '{8'd128, 1'b0, 1'b0, mk_res(0, 1'b0, 1'b0)},
            '{8'd254, 1'b1, 1'b0, mk_res(0, 1'b0, 1'b0)}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].data_byte, dir_rows[i].last_byte);
            // codes of this byte sit at the back of the queue right after the beat
            if (dir_rows[i].typed && (last_n == 0 ||
                pending_codes[pending_codes.size() - last_n] != dir_rows[i].first_res))
            begin
                $display("%0t: row %0d expected code %0d eos %0b bad %0b not predicted",
                         $time, i, dir_rows[i].first_res.code, dir_rows[i].first_res.eos,
                         dir_rows[i].first_res.bad);
                err_count++;
            end
        end

        cfg_list = '{8'd1, 8'd3, 8'd16, 8'd200, 8'd255, 8'd0};
        cfg_list[5] = 8'($urandom_range(2, 254));
        foreach (cfg_list[k])
        begin
            write_alphabet(cfg_list[k]);
            if (k == 1)
            begin
                // receiver holds off while bytes keep coming
                hold_req = 1'b1;
                random_streams(60);
                wait (!hold_req);
                // sender pause until all codes are back
                s_axis_tvalid <= 1'b0;
                wait (pending_codes.size() == 0);
                @(posedge clk);
            end
            random_streams(180);
        end

        // one long stream at full alphabet, first half with no idling
        write_alphabet(8'd255);
        steady = 1'b1;
        for (int i = 0; i < 240; i++)
        begin
            if (i == 120)
                steady = 1'b0;
            send_byte(8'($urandom_range(1, 255)), i == 239);
        end

        s_axis_tvalid <= 1'b0;
        wait (pending_codes.size() == 0);
        repeat (SETTLE) @(posedge clk);

        $display("bytes sent %0d, codes checked %0d, streams %0d", beats_in, beats_out,
                 streams_done);
        $display("alphabet sizes 1..255 covered, bad bytes, flushes, long output stall");
        if (err_count == 0)
            $display("lzw_compressor_top_tb: done, clean");
        else
            $display("lzw_compressor_top_tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/lzwc_pkg.sv
hw/rtl/lzwc_outq.sv
hw/rtl/lzw_compressor_top.sv
sim/lzw_compressor_top_tb.sv
